### rtl/serial_to_can_deframer_unit_defines.svh
// Assertion macros used by the deframer port checker.
`ifndef SERIAL_TO_CAN_DEFRAMER_UNIT_DEFINES_SVH
`define SERIAL_TO_CAN_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SCTD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");

// Next-cycle implication, disabled during reset.
`define SCTD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");

`endif

### rtl/sctd_pkg.sv
// Types and constants shared by the serial-to-CAN deframer.
package sctd_pkg;

	localparam logic [7:0] HeaderReset = 8'h24;
	localparam int         FrameBytes  = 8;

	typedef struct packed {
		logic       fire;
		logic       last;
		logic [7:0] data;
	} step_t;

	typedef struct packed {
		logic [FrameBytes-1:0][7:0] payload;
		logic [3:0]                 length;
		logic [10:0]                id;
	} frame_t;

	typedef struct packed {
		logic   valid;
		frame_t frame;
	} res_t;

endpackage

### rtl/serial_to_can_deframer_unit.sv
// Serial byte stream to CAN frame deframer, top level.
//
//  channel | dir | fields
//  s_*     | in  | tdata[7:0] data_byte, tlast burst_end
//  m_*     | out | tdata: frame_id, frame_length, payload_0..payload_7
//  cfg_*   | in  | cfg_wr_data header_value, written when cfg_wr_en
//
// One byte per cycle sustained while no held result stalls; each transaction
// enters the input register, and its frame, if any, then the result register.
// Reset puts the parser in header hunt with header_value 0x24.
// A held result stalls the input register only when both are occupied.
module serial_to_can_deframer_unit #(
	parameter int MAX_FRAME_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // frame_id, frame_length, payload_0..7, zero pad
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);
	import sctd_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic [7:0] header_q;
	step_t      step;
	res_t       res;

	assign step.fire = valid_s1 && (!res.valid || m_tready);
	assign step.last = last_s1;
	assign step.data = data_s1;
	assign s_tready  = !valid_s1 || step.fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			data_s1  <= 8'h00;
			last_s1  <= 1'b0;
			header_q <= HeaderReset;
		end else begin
			if (cfg_wr_en) begin
				header_q <= cfg_wr_data;
			end
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
				data_s1  <= s_tdata;
				last_s1  <= s_tlast;
			end else if (step.fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	sctd_parser #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.header_value(header_q),
		.step        (step),
		.res_ready   (m_tready),
		.res         (res)
	);

	assign m_tvalid = res.valid;
	assign m_tdata  = {1'b0, res.frame};

endmodule

### rtl/sctd_parser.sv
// Header hunt, count/id parsing and frame assembly with the result register.
module sctd_parser #(
	parameter int MAX_FRAME_BYTES = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     header_value,
	input  sctd_pkg::step_t step,
	input  logic           res_ready,
	output sctd_pkg::res_t res
);
	import sctd_pkg::*;

	localparam int         IdxW    = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
	localparam logic [3:0] MaxFill = 4'(MAX_FRAME_BYTES);

	typedef enum logic [1:0] {PhHunt, PhCount, PhIdLow, PhPayload} phase_t;

	phase_t     phase_q;
	logic [4:0] rem_q;
	logic [10:0] id_q;
	logic [7:0] bytes_q [MAX_FRAME_BYTES];
	logic [3:0] fill_q;
	logic       valid_q;
	frame_t     frame_q;

	logic [FrameBytes-1:0][7:0] held;
	logic [FrameBytes-1:0][7:0] merged;
	logic [4:0] count;
	logic [4:0] rem_dec;
	logic [3:0] fill_inc;
	logic       room;
	logic       emit;

	for (genvar g = 0; g < FrameBytes; g++) begin : g_held
		if (g < MAX_FRAME_BYTES) begin : g_used
			assign held[g] = bytes_q[g];
		end else begin : g_zero
			assign held[g] = 8'h00;
		end
	end

	assign count    = step.data[7:3];
	assign rem_dec  = rem_q - 5'd1;
	assign fill_inc = fill_q + 4'd1;
	assign room     = fill_q < MaxFill;
	assign emit     = (rem_dec == 5'd0) || (fill_inc >= MaxFill) || step.last;

	always_comb begin
		for (int i = 0; i < FrameBytes; i++) begin
			merged[i] = held[i];
			if (room && (fill_q == 4'(i))) begin
				merged[i] = step.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhHunt;
			rem_q   <= 5'd0;
			id_q    <= 11'd0;
			fill_q  <= 4'd0;
			valid_q <= 1'b0;
			frame_q <= '0;
			for (int i = 0; i < MAX_FRAME_BYTES; i++) begin
				bytes_q[i] <= 8'h00;
			end
		end else if (step.fire) begin
			valid_q <= (phase_q == PhPayload) && emit;
			case (phase_q)
				PhHunt: begin
					if (step.data == header_value) begin
						phase_q <= PhCount;
					end
				end
				PhCount: begin
					if (count == 5'd0) begin
						phase_q <= (step.data == header_value) ? PhCount : PhHunt;
					end else begin
						rem_q   <= count;
						id_q    <= {step.data[2:0], 8'h00};
						phase_q <= PhIdLow;
					end
				end
				PhIdLow: begin
					id_q[7:0] <= step.data;
					fill_q    <= 4'd0;
					phase_q   <= PhPayload;
					for (int i = 0; i < MAX_FRAME_BYTES; i++) begin
						bytes_q[i] <= 8'h00;
					end
				end
				PhPayload: begin
					rem_q <= rem_dec;
					if (rem_dec == 5'd0) begin
						phase_q <= PhHunt;
					end
					if (emit) begin
						frame_q.id      <= id_q;
						frame_q.length  <= room ? fill_inc : fill_q;
						frame_q.payload <= merged;
						fill_q          <= 4'd0;
						for (int i = 0; i < MAX_FRAME_BYTES; i++) begin
							bytes_q[i] <= 8'h00;
						end
					end else if (room) begin
						bytes_q[fill_q[IdxW-1:0]] <= step.data;
						fill_q                    <= fill_inc;
					end
				end
				default: begin
					phase_q <= PhHunt;
				end
			endcase
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign res.valid = valid_q;
	assign res.frame = frame_q;

endmodule

### rtl/sctd_checker.sv
// Port-level checker for the deframer, bound to the top level.
`include "serial_to_can_deframer_unit_defines.svh"

module sctd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata
);
	// stalled result transaction holds
	`SCTD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// frame length within one frame
	`SCTD_ASSERT_NOW(a_len, m_tvalid, (m_tdata[14:11] != 4'd0) && (m_tdata[14:11] <= 4'd8))
	// single-byte frame leaves the rest zero
	`SCTD_ASSERT_NOW(a_tail1, m_tvalid && (m_tdata[14:11] == 4'd1), m_tdata[79:23] == 57'd0)
	// last byte unused unless the frame is full
	`SCTD_ASSERT_NOW(a_tail7, m_tvalid && (m_tdata[14:11] != 4'd8), m_tdata[79:71] == 9'd0)
	// input side is open whenever no result is held
	`SCTD_ASSERT_NOW(a_ready, !m_tvalid, s_tready)

endmodule

bind serial_to_can_deframer_unit sctd_checker u_sctd_checker (.*);

### tb/can_frame_checker.sv
// Deframer checker: tracks header writes and accepted bytes, predicts frames, compares them.
module can_frame_checker
	import sctd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	output int          errors,
	output int          frames_pending,
	output int          frames_checked
);

	typedef enum logic [1:0] {
		SeekHeader,
		ReadCount,
		ReadIdLow,
		ReadPayload
	} parse_t;

	parse_t     phase;
	logic [7:0] header;
	logic [4:0] remaining;
	logic [10:0] msg_id;
	logic [7:0] held_bytes [FrameBytes];
	int         fill;
	frame_t     expected_frames [$];

	task automatic parse_byte(input logic [7:0] b, input logic burst_end);
		frame_t f;
		case (phase)
			SeekHeader: begin
				if (b == header)
					phase = ReadCount;
			end
			ReadCount: begin
				if (b[7:3] == 5'd0) begin
					phase = (b == header) ? ReadCount : SeekHeader;
				end else begin
					remaining = b[7:3];
					msg_id    = {b[2:0], 8'h00};
					phase     = ReadIdLow;
				end
			end
			ReadIdLow: begin
				msg_id[7:0] = b;
				fill = 0;
				foreach (held_bytes[k]) held_bytes[k] = 8'h00;
				phase = ReadPayload;
			end
			ReadPayload: begin
				if (fill < FrameBytes) begin
					held_bytes[fill] = b;
					fill++;
				end
				if (remaining != 5'd0)
					remaining--;
				if (remaining == 5'd0)
					phase = SeekHeader;
				if (remaining == 5'd0 || fill >= FrameBytes || burst_end) begin
					f.id     = msg_id;
					f.length = 4'(fill);
					for (int k = 0; k < FrameBytes; k++)
						f.payload[k] = held_bytes[k];
					expected_frames.push_back(f);
					fill = 0;
					foreach (held_bytes[k]) held_bytes[k] = 8'h00;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_t got;
		frame_t want;
		if (!arst_n) begin
			phase     = SeekHeader;
			header    = HeaderReset;
			remaining = 5'd0;
			msg_id    = 11'd0;
			fill      = 0;
			foreach (held_bytes[k]) held_bytes[k] = 8'h00;
			expected_frames.delete();
			errors         = 0;
			frames_checked = 0;
			frames_pending = 0;
		end else begin
			if (cfg_wr_en)
				header = cfg_wr_data;
			// outgoing frame belongs to an earlier byte, so compare before predicting
			if (m_tvalid && m_tready) begin
				got = frame_t'(m_tdata[78:0]);
				if (expected_frames.size() == 0) begin
					errors++;
					$display("%0t: unexpected frame: expected none, actual %h", $time, m_tdata);
				end else begin
					want = expected_frames.pop_front();
					frames_checked++;
					if (got.id !== want.id) begin
						errors++;
						$display("%0t: frame_id expected %h actual %h", $time, want.id, got.id);
					end
					if (got.length !== want.length) begin
						errors++;
						$display("%0t: frame_length expected %0d actual %0d",
							$time, want.length, got.length);
					end
					for (int k = 0; k < FrameBytes; k++) begin
						if (got.payload[k] !== want.payload[k]) begin
							errors++;
							$display("%0t: payload_%0d expected %h actual %h",
								$time, k, want.payload[k], got.payload[k]);
						end
					end
				end
			end
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tlast);
			frames_pending = expected_frames.size();
		end
	end

endmodule

### tb/tb_serial_to_can_deframer_unit.sv
// Testbench top for the serial-to-CAN deframer: byte stimulus, header settings, verdict.
module tb_serial_to_can_deframer_unit;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tlast;   // burst_end
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;   // [10:0] id, [14:11] length, [22:15] payload_0 .. [78:71] payload_7
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;

	int         errors;
	int         frames_pending;
	int         frames_checked;
	logic [7:0] hdr;
	logic       steady;
	int         msg_bytes;
	int         settings_run;

	serial_to_can_deframer_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	can_frame_checker frame_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.errors        (errors),
		.frames_pending(frames_pending),
		.frames_checked(frames_checked)
	);

	initial begin
		clk = 1'b0;
	end

	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	// frame sink with random stalls
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = steady ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic burst_end);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= burst_end;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and let every predicted frame come out
	task automatic drain();
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (frames_pending != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic set_header(input logic [7:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		hdr = v;
		settings_run++;
	endtask

	task automatic send_message();
		int         n;
		logic [7:0] b;
		logic [2:0] id_hi;
		repeat ($urandom_range(0, 2)) begin
			do b = 8'($urandom); while (b == hdr);
			send_byte(b, $urandom_range(0, 7) == 0);
		end
		n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 9) : $urandom_range(10, 31);
		id_hi = 3'($urandom_range(0, 7));
		send_byte(hdr, $urandom_range(0, 9) == 0);
		send_byte({5'(n), id_hi}, $urandom_range(0, 9) == 0);
		send_byte(8'($urandom), $urandom_range(0, 9) == 0);
		repeat (n) send_byte(8'($urandom), $urandom_range(0, 9) == 0);
		msg_bytes += n + 3;
	endtask

	task automatic send_garbage();
		if ($urandom_range(0, 2) == 0) begin
			send_byte(hdr, 1'($urandom_range(0, 1)));
			send_byte({5'd0, 3'($urandom_range(0, 7))}, 1'($urandom_range(0, 1)));
		end
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 3) == 0)
				send_byte(hdr, $urandom_range(0, 3) == 0);
			else
				send_byte(8'($urandom), $urandom_range(0, 3) == 0);
		end
	endtask

	initial begin
		logic paused;
		int   phase_bytes;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = 8'h00;
		s_tlast      = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = 8'h00;
		steady       = 1'b0;
		msg_bytes    = 0;
		settings_run = 0;
		hdr          = sctd_pkg::HeaderReset;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: noise while hunting, zero count, full/partial/count-done frames, split header
		set_header(sctd_pkg::HeaderReset);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h24, 1'b0);
		send_byte(8'h07, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h24, 1'b0);
		send_byte(8'h57, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h3C, 1'b1);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h24, 1'b1);
		send_byte(8'h08, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b1);
		// zero count equal to a small header keeps waiting for the count
		set_header(8'h05);
		send_byte(8'h05, 1'b0);
		send_byte(8'h05, 1'b0);
		send_byte(8'h0D, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h99, 1'b0);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_header(8'h00);
				1: set_header(8'hFF);
				4: set_header(sctd_pkg::HeaderReset);
				default: set_header(8'($urandom));
			endcase
			paused      = 1'b0;
			phase_bytes = msg_bytes;
			while (msg_bytes - phase_bytes < 240) begin
				if (!paused && msg_bytes - phase_bytes >= 120) begin
					drain();
					paused = 1'b1;
				end
				steady = ($urandom_range(0, 7) == 0);
				if ($urandom_range(0, 4) != 0)
					send_message();
				else
					send_garbage();
			end
		end
		steady = 1'b0;
		drain();
		repeat (20) @(posedge clk);

		$display("Ran %0d message bytes under %0d header settings, %0d frames compared",
			msg_bytes, settings_run, frames_checked);
		$display("Covered noise, zero counts, burst splits, full frames and multi-frame messages");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
